@@ design/pom_pkg.sv @@
// ----------------------------------------------------------------------------
// pom_pkg: shared types and constants of the perturb-and-observe tracker
// Field widths, register codes, reset values and the queue entry layout.
// ----------------------------------------------------------------------------
package pom_pkg;

  // fixed field widths
  localparam int unsigned ChanW   = 2;
  localparam int unsigned DutyW   = 16;
  localparam int unsigned SenseW  = 16;
  localparam int unsigned PowerW  = 33;
  localparam int unsigned CfgIdxW = 2;

  // defaults for top-level parameters
  localparam int unsigned DefaultChannels   = 3;
  localparam int unsigned DefaultStartDuty  = 0;
  localparam int unsigned DefaultQueueDepth = 2;

  // register reset values
  localparam logic [DutyW-1:0] MinDutyRst  = 16'h0000;
  localparam logic [DutyW-1:0] MaxDutyRst  = 16'hFFFF;
  localparam logic [DutyW-1:0] DutyStepRst = 16'h0001;

  // register index codes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_DUTY  = 2'd0,
    CFG_MAX_DUTY  = 2'd1,
    CFG_DUTY_STEP = 2'd2
  } cfg_idx_e;

  // configuration seen by the back end
  typedef struct packed {
    logic [DutyW-1:0] min_duty;
    logic [DutyW-1:0] max_duty;
    logic [DutyW-1:0] duty_step;
  } cfg_t;

  // classified item waiting in the queue
  typedef struct packed {
    logic [ChanW-1:0]  channel;
    logic              chan_ok;
    logic              error;
    logic [PowerW-1:0] power;
  } q_entry_t;

  // queue status toward its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ design/pom_front.sv @@
// ----------------------------------------------------------------------------
// pom_front: item intake and classification
// Accepts an item, checks the channel and sensor flag, computes the power.
// ----------------------------------------------------------------------------
module pom_front #(
  parameter int unsigned CHANNELS = pom_pkg::DefaultChannels
) (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pom_pkg::ChanW-1:0]   channel_i,
  input  logic [pom_pkg::SenseW-1:0]  current_a_i,
  input  logic [pom_pkg::SenseW-1:0]  current_b_i,
  input  logic [pom_pkg::SenseW-1:0]  voltage_i,
  input  logic                        sensor_error_i,
  input  pom_pkg::q_status_t          q_status_i,
  output logic                        push_o,
  output pom_pkg::q_entry_t           entry_o
);
  import pom_pkg::*;

  localparam logic [4:0] ChanLimit = 5'(CHANNELS);

  logic              chan_ok;
  logic              err;
  logic [SenseW:0]   cur_sum;
  logic [PowerW-1:0] prod;

  // channel check and error flag
  assign chan_ok = ({3'b000, channel_i} < ChanLimit);
  assign err     = !chan_ok || sensor_error_i;

  // (a + b) * v, 17 by 16 bits, exact in 33 bits
  assign cur_sum = {1'b0, current_a_i} + {1'b0, current_b_i};
  assign prod    = {{(PowerW-SenseW-1){1'b0}}, cur_sum} * {{(PowerW-SenseW){1'b0}}, voltage_i};

  // stall only on a full queue
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    entry_o.channel = channel_i;
    entry_o.chan_ok = chan_ok;
    entry_o.error   = err;
    entry_o.power   = err ? '0 : prod;
  end

endmodule

@@ design/pom_queue.sv @@
// ----------------------------------------------------------------------------
// pom_queue: short FIFO between front and back end
// Registered entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module pom_queue #(
  parameter int unsigned Depth = pom_pkg::DefaultQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pom_pkg::q_entry_t  data_i,
  input  logic               pop_i,
  output pom_pkg::q_entry_t  data_o,
  output pom_pkg::q_status_t status_o
);
  import pom_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/pom_back.sv @@
// ----------------------------------------------------------------------------
// pom_back: tracking step and result register
// Holds per-channel state and the duty limits, decides the direction,
// moves the duty and presents the result.
// ----------------------------------------------------------------------------
module pom_back #(
  parameter int unsigned CHANNELS   = pom_pkg::DefaultChannels,
  parameter int unsigned START_DUTY = pom_pkg::DefaultStartDuty
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pom_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pom_pkg::DutyW-1:0]   cfg_data_i,
  input  pom_pkg::q_status_t          q_status_i,
  input  pom_pkg::q_entry_t           entry_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pom_pkg::ChanW-1:0]   channel_out_o,
  output logic [pom_pkg::DutyW-1:0]   pwm_duty_o,
  output logic                        increasing_o,
  output logic [pom_pkg::PowerW-1:0]  power_o,
  output logic                        error_o
);
  import pom_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [DutyW-1:0] StartDuty = DutyW'(START_DUTY);

  cfg_t              cfg_q;
  logic [PowerW-1:0] last_power_q [CHANNELS];
  logic              last_dir_q   [CHANNELS];
  logic [DutyW-1:0]  duty_q       [CHANNELS];

  logic              out_valid_q;
  logic [ChanW-1:0]  out_chan_q;
  logic [DutyW-1:0]  out_duty_q;
  logic              out_dir_q;
  logic [PowerW-1:0] out_power_q;
  logic              out_err_q;

  logic [IdxW-1:0]   idx;
  logic [DutyW-1:0]  duty_old;
  logic              dir_old;
  logic              dir_new;
  logic [DutyW-1:0]  duty_new;
  logic [DutyW:0]    duty_sum;
  logic              res_dir;
  logic [DutyW-1:0]  res_duty;
  logic              upd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_duty  <= MinDutyRst;
      cfg_q.max_duty  <= MaxDutyRst;
      cfg_q.duty_step <= DutyStepRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DUTY:  cfg_q.min_duty  <= cfg_data_i;
        CFG_MAX_DUTY:  cfg_q.max_duty  <= cfg_data_i;
        CFG_DUTY_STEP: cfg_q.duty_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pop whenever the result register is free or being emptied
  assign pop_o = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign upd   = pop_o && !entry_i.error;

  // read the channel's state
  assign idx      = IdxW'(entry_i.channel);
  assign duty_old = duty_q[idx];
  assign dir_old  = last_dir_q[idx];

  // direction: zero power forces decrease, a drop reverses
  always_comb begin
    if (entry_i.power == '0) begin
      dir_new = 1'b0;
    end else if (entry_i.power < last_power_q[idx]) begin
      dir_new = !dir_old;
    end else begin
      dir_new = dir_old;
    end
  end

  // duty step with clamps and saturation
  assign duty_sum = {1'b0, duty_old} + {1'b0, cfg_q.duty_step};
  always_comb begin
    if (dir_new) begin
      if (duty_old >= cfg_q.max_duty) begin
        duty_new = cfg_q.max_duty;
      end else begin
        duty_new = duty_sum[DutyW] ? '1 : duty_sum[DutyW-1:0];
      end
    end else begin
      if (duty_old <= cfg_q.min_duty) begin
        duty_new = cfg_q.min_duty;
      end else if (cfg_q.duty_step >= duty_old) begin
        duty_new = '0;
      end else begin
        duty_new = duty_old - cfg_q.duty_step;
      end
    end
  end

  // result fields: invalid channel shows zeros, sensor error shows state
  always_comb begin
    if (!entry_i.chan_ok) begin
      res_dir  = 1'b0;
      res_duty = '0;
    end else if (entry_i.error) begin
      res_dir  = dir_old;
      res_duty = duty_old;
    end else begin
      res_dir  = dir_new;
      res_duty = duty_new;
    end
  end

  // per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_power_q[i] <= '0;
        last_dir_q[i]   <= 1'b0;
        duty_q[i]       <= StartDuty;
      end
    end else if (upd) begin
      last_power_q[idx] <= entry_i.power;
      last_dir_q[idx]   <= dir_new;
      duty_q[idx]       <= duty_new;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_chan_q  <= entry_i.channel;
      out_duty_q  <= res_duty;
      out_dir_q   <= res_dir;
      out_power_q <= entry_i.power;
      out_err_q   <= entry_i.error;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_chan_q;
  assign pwm_duty_o    = out_duty_q;
  assign increasing_o  = out_dir_q;
  assign power_o       = out_power_q;
  assign error_o       = out_err_q;

endmodule

@@ design/perturb_observe_mppt_core.sv @@
// ----------------------------------------------------------------------------
// perturb_observe_mppt_core: perturb-and-observe tracker for solar channels
// One item per cycle unless stalled; each item yields one result with duty and direction.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while the queue is not full and returns one
// result per item, in order. The front end checks the channel, takes the sensor
// flag and multiplies (current_a + current_b) by voltage; the item then waits in
// a short queue of QUEUE_DEPTH entries. The back end takes one item a cycle from
// the queue while the result register is free or being emptied, updates that
// channel's power, direction and duty in flip-flops unless the item has an
// error, and loads the result register. The state update and the result load
// happen in the same cycle, so the next item sees the update. The user must
// write the duty limits and step only while the block is idle; the block itself does not enforce this.
module perturb_observe_mppt_core #(
  parameter int unsigned CHANNELS    = pom_pkg::DefaultChannels,
  parameter int unsigned START_DUTY  = pom_pkg::DefaultStartDuty,
  parameter int unsigned QUEUE_DEPTH = pom_pkg::DefaultQueueDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pom_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pom_pkg::DutyW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [pom_pkg::ChanW-1:0]   channel_i,
  input  logic [pom_pkg::SenseW-1:0]  current_a_i,
  input  logic [pom_pkg::SenseW-1:0]  current_b_i,
  input  logic [pom_pkg::SenseW-1:0]  voltage_i,
  input  logic                        sensor_error_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [pom_pkg::ChanW-1:0]   channel_out_o,
  output logic [pom_pkg::DutyW-1:0]   pwm_duty_o,
  output logic                        increasing_o,
  output logic [pom_pkg::PowerW-1:0]  power_o,
  output logic                        error_o
);
  import pom_pkg::*;

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head_entry;
  logic      push;
  logic      pop;

  // intake and classification
  pom_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .channel_i      (channel_i),
    .current_a_i    (current_a_i),
    .current_b_i    (current_b_i),
    .voltage_i      (voltage_i),
    .sensor_error_i (sensor_error_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // queue between the two ends
  pom_queue #(
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_entry),
    .pop_i    (pop),
    .data_o   (head_entry),
    .status_o (q_status)
  );

  // tracking step and result register
  pom_back #(
    .CHANNELS  (CHANNELS),
    .START_DUTY(START_DUTY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_status_i    (q_status),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_o (channel_out_o),
    .pwm_duty_o    (pwm_duty_o),
    .increasing_o  (increasing_o),
    .power_o       (power_o),
    .error_o       (error_o)
  );

endmodule
